// ===== rtl/core/tapg_pkg.sv =====
// Shared types and constants for the two-axis PID gimbal step block.
// No dependencies; imported by the lane, merge and top modules.
package tapg_pkg;

	// register indexes on the configuration port
	localparam logic [2:0] REG_CENTER_X  = 3'd0;
	localparam logic [2:0] REG_CENTER_Y  = 3'd1;
	localparam logic [2:0] REG_GAIN_P    = 3'd2;
	localparam logic [2:0] REG_GAIN_I    = 3'd3;
	localparam logic [2:0] REG_GAIN_D    = 3'd4;
	localparam logic [2:0] REG_INT_LIMIT = 3'd5;

	// register reset values
	localparam logic [14:0] CENTER_X_RST  = 15'd240;
	localparam logic [14:0] CENTER_Y_RST  = 15'd320;
	localparam logic [15:0] GAIN_P_RST    = 16'd3277;
	localparam logic [15:0] GAIN_I_RST    = 16'd655;
	localparam logic [15:0] GAIN_D_RST    = 16'd655;
	localparam logic [14:0] INT_LIMIT_RST = 15'd3000;

	// servo angle ranges and start angles, in degrees
	localparam logic [7:0] PITCH_MIN  = 8'd40;
	localparam logic [7:0] PITCH_MAX  = 8'd100;
	localparam logic [7:0] PITCH_INIT = 8'd60;
	localparam logic [7:0] YAW_MIN    = 8'd35;
	localparam logic [7:0] YAW_MAX    = 8'd145;
	localparam logic [7:0] YAW_INIT   = 8'd90;

	// degrees to hundredths of a degree
	localparam logic [13:0] CENTI = 14'd100;

	// drive saturation; any larger magnitude pins the angle at a bound anyway
	localparam logic signed [9:0] DRIVE_MAX = 10'sd255;

	typedef struct packed {
		logic [14:0] target_x_position;
		logic [14:0] target_y_position;
	} tapg_in_t;

	typedef struct packed {
		logic [13:0] pitch_cmd_centideg;
		logic [13:0] yaw_cmd_centideg;
	} tapg_out_t;

	typedef struct packed {
		logic [15:0] p;
		logic [15:0] i;
		logic [15:0] d;
	} tapg_gain_t;

	typedef struct packed {
		logic [7:0] lo;
		logic [7:0] hi;
		logic [7:0] init;
	} tapg_bounds_t;

	// stage load strobes, shared by both lanes and the merge stage
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic o;
	} tapg_adv_t;

endpackage

// ===== rtl/core/tapg_lane.sv =====
// One axis of the PID step: error and integral, products, sum, drive, angle.
// Depends on tapg_pkg for the stage strobes, gain and bounds structs.
module tapg_lane (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tapg_pkg::tapg_adv_t    adv,
	input  logic [14:0]           pos,
	input  logic [14:0]           center,
	input  logic [14:0]           limit,
	input  tapg_pkg::tapg_gain_t   gain,
	input  tapg_pkg::tapg_bounds_t bounds,
	output logic [7:0]            angle_next
);
	import tapg_pkg::*;

	logic signed [15:0] integral_q;
	logic signed [15:0] last_err_q;
	logic        [7:0]  angle_q;

	logic signed [15:0] err;
	logic signed [16:0] int_sum;
	logic signed [16:0] lim_s;
	logic signed [15:0] int_new;
	logic signed [16:0] derr;

	logic signed [15:0] err_s1;
	logic signed [15:0] int_s1;
	logic signed [16:0] derr_s1;

	logic signed [32:0] prod_p_s2;
	logic signed [32:0] prod_i_s2;
	logic signed [33:0] prod_d_s2;

	logic signed [35:0] sum_s3;

	logic signed [35:0] sum_adj;
	logic signed [19:0] drive_full;
	logic signed [9:0]  drive_sat;
	logic signed [9:0]  drive_s4;

	logic signed [10:0] ang_diff;
	logic signed [10:0] ang_lo_s;
	logic signed [10:0] ang_hi_s;

	// error, clamped integral and error change
	always_comb begin
		err     = $signed({1'b0, pos}) - $signed({1'b0, center});
		int_sum = 17'(integral_q) + 17'(err);
		lim_s   = $signed({2'b00, limit});
		if (int_sum > lim_s) begin
			int_new = 16'(lim_s);
		end else if (int_sum < -lim_s) begin
			int_new = 16'(-lim_s);
		end else begin
			int_new = 16'(int_sum);
		end
		derr = 17'(err) - 17'(last_err_q);
	end

	// hold the controller state; advance it as a word enters the lane
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integral_q <= '0;
			last_err_q <= '0;
		end else if (adv.s1) begin
			integral_q <= int_new;
			last_err_q <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			err_s1  <= err;
			int_s1  <= int_new;
			derr_s1 <= derr;
		end
	end

	// the three gain products
	always_ff @(posedge clk) begin
		if (adv.s2) begin
			prod_p_s2 <= $signed({1'b0, gain.p}) * err_s1;
			prod_i_s2 <= $signed({1'b0, gain.i}) * int_s1;
			prod_d_s2 <= $signed({1'b0, gain.d}) * derr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			sum_s3 <= 36'(prod_p_s2) + 36'(prod_i_s2) + 36'(prod_d_s2);
		end
	end

	// divide by 2^16 toward zero, then saturate to a narrow drive
	always_comb begin
		sum_adj    = sum_s3 + (sum_s3[35] ? 36'sd65535 : 36'sd0);
		drive_full = 20'(sum_adj >>> 16);
		if (drive_full > 20'(DRIVE_MAX)) begin
			drive_sat = DRIVE_MAX;
		end else if (drive_full < -20'(DRIVE_MAX)) begin
			drive_sat = -DRIVE_MAX;
		end else begin
			drive_sat = 10'(drive_full);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			drive_s4 <= drive_sat;
		end
	end

	// step the servo angle and clamp it to the axis range
	always_comb begin
		ang_lo_s = $signed({3'b000, bounds.lo});
		ang_hi_s = $signed({3'b000, bounds.hi});
		ang_diff = $signed({3'b000, angle_q}) - 11'(drive_s4);
		if (ang_diff < ang_lo_s) begin
			angle_next = bounds.lo;
		end else if (ang_diff > ang_hi_s) begin
			angle_next = bounds.hi;
		end else begin
			angle_next = ang_diff[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			angle_q <= bounds.init;
		end else if (adv.o) begin
			angle_q <= angle_next;
		end
	end

endmodule

// ===== rtl/core/tapg_merge.sv =====
// Output register: joins both lane angles into one result word in centidegrees.
// Depends on tapg_pkg for the result struct and stage strobes.
module tapg_merge (
	input  logic                clk,
	input  tapg_pkg::tapg_adv_t adv,
	input  logic [7:0]          pitch_angle,
	input  logic [7:0]          yaw_angle,
	output tapg_pkg::tapg_out_t word_q
);
	import tapg_pkg::*;

	// scale and load both angles as the word leaves the lanes
	always_ff @(posedge clk) begin
		if (adv.o) begin
			word_q.pitch_cmd_centideg <= 14'(pitch_angle) * CENTI;
			word_q.yaw_cmd_centideg   <= 14'(yaw_angle) * CENTI;
		end
	end

endmodule

// ===== rtl/core/two_axis_pid_gimbal_step_top.sv =====
// Two-axis PID gimbal step, top level: config registers, pipeline control, lanes.
// Throughput: one word per cycle, unless out_ready holds off the result and stalls the pipeline.
// Each axis lane runs error/integral, product, sum, drive and angle stages in lockstep.
// Integral and last error update at input accept, the servo angle at the output load.
// Reset (arst_n low, asynchronous): registers to defaults, integrals and errors to zero,
// angles to 60 and 90 degrees, pipeline empty.
module two_axis_pid_gimbal_step_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  tapg_pkg::tapg_in_t  in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output tapg_pkg::tapg_out_t out_word,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import tapg_pkg::*;

	logic [14:0] center_x_q;
	logic [14:0] center_y_q;
	logic [14:0] int_limit_q;
	tapg_gain_t  gain_q;

	logic v_s1, v_s2, v_s3, v_s4;
	tapg_adv_t adv;

	logic [7:0] pitch_next;
	logic [7:0] yaw_next;

	tapg_bounds_t pitch_bounds;
	tapg_bounds_t yaw_bounds;

	// write the configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q  <= CENTER_X_RST;
			center_y_q  <= CENTER_Y_RST;
			gain_q.p    <= GAIN_P_RST;
			gain_q.i    <= GAIN_I_RST;
			gain_q.d    <= GAIN_D_RST;
			int_limit_q <= INT_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CENTER_X:  center_x_q  <= cfg_data[14:0];
				REG_CENTER_Y:  center_y_q  <= cfg_data[14:0];
				REG_GAIN_P:    gain_q.p    <= cfg_data;
				REG_GAIN_I:    gain_q.i    <= cfg_data;
				REG_GAIN_D:    gain_q.d    <= cfg_data;
				REG_INT_LIMIT: int_limit_q <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	// load a stage when its source is valid and it is empty or draining
	always_comb begin
		adv.o    = v_s4 && (!out_valid || out_ready);
		adv.s4   = v_s3 && (!v_s4 || adv.o);
		adv.s3   = v_s2 && (!v_s3 || adv.s4);
		adv.s2   = v_s1 && (!v_s2 || adv.s3);
		in_ready = !v_s1 || adv.s2;
		adv.s1   = in_valid && in_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= adv.s1 || (v_s1 && !adv.s2);
			v_s2      <= adv.s2 || (v_s2 && !adv.s3);
			v_s3      <= adv.s3 || (v_s3 && !adv.s4);
			v_s4      <= adv.s4 || (v_s4 && !adv.o);
			out_valid <= adv.o || (out_valid && !out_ready);
		end
	end

	assign pitch_bounds = '{lo: PITCH_MIN, hi: PITCH_MAX, init: PITCH_INIT};
	assign yaw_bounds   = '{lo: YAW_MIN, hi: YAW_MAX, init: YAW_INIT};

	tapg_lane u_pitch (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.pos        (in_word.target_x_position),
		.center     (center_x_q),
		.limit      (int_limit_q),
		.gain       (gain_q),
		.bounds     (pitch_bounds),
		.angle_next (pitch_next)
	);

	tapg_lane u_yaw (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.pos        (in_word.target_y_position),
		.center     (center_y_q),
		.limit      (int_limit_q),
		.gain       (gain_q),
		.bounds     (yaw_bounds),
		.angle_next (yaw_next)
	);

	tapg_merge u_merge (
		.clk         (clk),
		.adv         (adv),
		.pitch_angle (pitch_next),
		.yaw_angle   (yaw_next),
		.word_q      (out_word)
	);

	// a valid result always lies in the servo ranges
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.pitch_cmd_centideg >= 14'd4000 &&
			out_word.pitch_cmd_centideg <= 14'd10000))
		else $error("pitch command out of range");

	a_yaw_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_word.yaw_cmd_centideg >= 14'd3500 &&
			out_word.yaw_cmd_centideg <= 14'd14500))
		else $error("yaw command out of range");

	// a word leaving the last lane stage shows up as a result
	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && (!out_valid || out_ready)) |=> out_valid)
		else $error("lane word lost at output");

	// a stalled result keeps the last stage from overwriting it
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !adv.o)
		else $error("output overwritten while stalled");

endmodule

// ===== dv/gimbal_step_checker.sv =====
// Scoreboard for the two-axis PID gimbal step: follows register writes, predicts each
// angle word from the accepted position words, and compares the words that come out.
// Depends on tapg_pkg for the word types, register indexes, reset values and bounds.
module gimbal_step_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_ready,
	input  tapg_pkg::tapg_in_t  in_word,
	input  logic                out_valid,
	input  logic                out_ready,
	input  tapg_pkg::tapg_out_t out_word,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data,
	output int                  mismatches,
	output int                  pending,
	output int                  checked,
	output int                  at_stop
);
	timeunit 1ns;
	timeprecision 1ps;
	import tapg_pkg::*;

	typedef struct {
		logic signed [15:0] integral;
		logic signed [16:0] last_err;
		logic [7:0]         angle;
	} axis_state_t;

	// shadow registers
	logic [14:0] center_x;
	logic [14:0] center_y;
	logic [15:0] gain_p;
	logic [15:0] gain_i;
	logic [15:0] gain_d;
	logic [14:0] int_limit;

	axis_state_t pitch_st;
	axis_state_t yaw_st;
	tapg_out_t   expected_angles[$];
	tapg_out_t   predicted;
	tapg_out_t   oldest;

	// One PID update of one axis: clamped integral, truncated drive, clamped angle
	function automatic axis_state_t step_axis(axis_state_t s, logic [14:0] pos,
			logic [14:0] center, logic [7:0] lo, logic [7:0] hi);
		longint err;
		longint acc;
		longint sum;
		longint drive;
		longint ang;
		longint lim;
		axis_state_t n;
		lim = longint'(int_limit);
		err = longint'(pos) - longint'(center);
		acc = longint'(s.integral) + err;
		if (acc > lim)
			acc = lim;
		if (acc < -lim)
			acc = -lim;
		sum = longint'(gain_p) * err + longint'(gain_i) * acc
			+ longint'(gain_d) * (err - longint'(s.last_err));
		// signed division truncates toward zero
		drive = sum / 65536;
		ang = longint'(s.angle) - drive;
		if (ang < longint'(lo))
			ang = longint'(lo);
		if (ang > longint'(hi))
			ang = longint'(hi);
		n.integral = 16'(acc);
		n.last_err = 17'(err);
		n.angle    = 8'(ang);
		return n;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x  = CENTER_X_RST;
			center_y  = CENTER_Y_RST;
			gain_p    = GAIN_P_RST;
			gain_i    = GAIN_I_RST;
			gain_d    = GAIN_D_RST;
			int_limit = INT_LIMIT_RST;
			pitch_st  = '{16'sd0, 17'sd0, PITCH_INIT};
			yaw_st    = '{16'sd0, 17'sd0, YAW_INIT};
			expected_angles.delete();
			pending <= 0;
		end else begin
			// track register writes; unknown indexes do nothing, upper bits drop
			if (cfg_we) begin
				case (cfg_index)
					REG_CENTER_X:  center_x  = cfg_data[14:0];
					REG_CENTER_Y:  center_y  = cfg_data[14:0];
					REG_GAIN_P:    gain_p    = cfg_data;
					REG_GAIN_I:    gain_i    = cfg_data;
					REG_GAIN_D:    gain_d    = cfg_data;
					REG_INT_LIMIT: int_limit = cfg_data[14:0];
					default: ;
				endcase
			end

			// compare an accepted output word with the oldest prediction
			if (out_valid && out_ready) begin
				if (expected_angles.size() == 0) begin
					$error("angle word with no position word waiting: %h",
						out_word);
					mismatches++;
				end else begin
					oldest = expected_angles.pop_front();
					checked++;
					if (out_word.pitch_cmd_centideg !==
							oldest.pitch_cmd_centideg) begin
						$error("pitch_cmd_centideg: expected %0d, got %0d",
							oldest.pitch_cmd_centideg, out_word.pitch_cmd_centideg);
						mismatches++;
					end
					if (out_word.yaw_cmd_centideg !==
							oldest.yaw_cmd_centideg) begin
						$error("yaw_cmd_centideg: expected %0d, got %0d",
							oldest.yaw_cmd_centideg, out_word.yaw_cmd_centideg);
						mismatches++;
					end
				end
			end

			// advance both axes on an accepted position word
			if (in_valid && in_ready) begin
				pitch_st = step_axis(pitch_st, in_word.target_x_position, center_x,
					PITCH_MIN, PITCH_MAX);
				yaw_st = step_axis(yaw_st, in_word.target_y_position, center_y,
					YAW_MIN, YAW_MAX);
				predicted.pitch_cmd_centideg = 14'(pitch_st.angle) * CENTI;
				predicted.yaw_cmd_centideg   = 14'(yaw_st.angle) * CENTI;
				if (pitch_st.angle == PITCH_MIN || pitch_st.angle == PITCH_MAX ||
						yaw_st.angle == YAW_MIN || yaw_st.angle == YAW_MAX)
					at_stop++;
				expected_angles.push_back(predicted);
			end
			pending <= expected_angles.size();
		end
	end

endmodule

// ===== dv/two_axis_pid_gimbal_step_top_test.sv =====
// Testbench top for the two-axis PID gimbal step: clock, reset, register settings,
// position words with bursty flow, stalling angle receiver, watchdog and verdict.
// Depends on tapg_pkg, two_axis_pid_gimbal_step_top and gimbal_step_checker.
module two_axis_pid_gimbal_step_top_test;
	timeunit 1ns;
	timeprecision 1ps;
	import tapg_pkg::*;

	localparam int WORDS_PER_PHASE = 123;
	localparam int PHASES          = 10;
	localparam int IDLE_LIMIT      = 2000;
	localparam int SETTLE_CYCLES   = 20;

	typedef enum int {
		SET_DEFAULT, SET_MILD, SET_MAX, SET_NO_GAIN, SET_NO_INTEGRAL, SET_RANDOM,
		SET_EDGE_CENTER
	} regs_kind_e;

	typedef struct {
		logic [14:0] center_x;
		logic [14:0] center_y;
		logic [15:0] gain_p;
		logic [15:0] gain_i;
		logic [15:0] gain_d;
		logic [14:0] int_limit;
	} gimbal_regs_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_ready;
	tapg_in_t    in_word   = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	tapg_out_t   out_word;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = REG_CENTER_X;
	logic [15:0] cfg_data  = '0;

	int mismatches;
	int pending;
	int checked;
	int at_stop;
	int idle_cycles = 0;
	int burst_left  = 0;
	int settings_written = 0;
	logic [1:0]  stall_mode = 2'd0;
	logic [5:0]  stall_tick = '0;
	logic [14:0] walk_x = 15'd240;
	logic [14:0] walk_y = 15'd320;
	gimbal_regs_t regs;
	regs_kind_e   phase_kinds[PHASES];

	two_axis_pid_gimbal_step_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_word  (out_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	gimbal_step_checker u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_word   (out_word),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.mismatches (mismatches),
		.pending    (pending),
		.checked    (checked),
		.at_stop    (at_stop)
	);

	always #2 clk = ~clk;

	// receiver: a new stall pattern is picked each time stall_tick wraps, one pattern never stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			stall_tick <= stall_tick + 6'd1;
			if (stall_tick == '0)
				stall_mode <= 2'($urandom_range(0, 3));
			case (stall_mode)
				2'd0: out_ready <= 1'b1;
				2'd1: out_ready <= ($urandom_range(0, 3) != 0);
				2'd2: out_ready <= stall_tick[2];
				default: out_ready <= 1'($urandom);
			endcase
		end
	end

	// watchdog: end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// hold a word until accepted, then either keep streaming or take a gap
	task automatic send_word(tapg_in_t w);
		in_word  <= w;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 200)
				: $urandom_range(0, 30);
		end else begin
			burst_left--;
		end
	endtask

	task automatic send_xy(int x, int y);
		tapg_in_t w;
		w.target_x_position = 15'(x);
		w.target_y_position = 15'(y);
		send_word(w);
	endtask

	// stop sending and wait until every predicted word has come out
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// write all six registers, then one unused index, with junk in unused bits
	task automatic apply_settings(gimbal_regs_t r);
		regs = r;
		cfg_we    <= 1'b1;
		cfg_index <= REG_CENTER_X;
		cfg_data  <= {1'($urandom), r.center_x};
		@(posedge clk);
		cfg_index <= REG_CENTER_Y;
		cfg_data  <= {1'($urandom), r.center_y};
		@(posedge clk);
		cfg_index <= REG_GAIN_P;
		cfg_data  <= r.gain_p;
		@(posedge clk);
		cfg_index <= REG_GAIN_I;
		cfg_data  <= r.gain_i;
		@(posedge clk);
		cfg_index <= REG_GAIN_D;
		cfg_data  <= r.gain_d;
		@(posedge clk);
		cfg_index <= REG_INT_LIMIT;
		cfg_data  <= {1'($urandom), r.int_limit};
		@(posedge clk);
		cfg_index <= REG_INT_LIMIT + 3'd1 + 3'($urandom_range(0, 1));
		cfg_data  <= 16'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_written++;
	endtask

	function automatic gimbal_regs_t pick_regs(regs_kind_e kind);
		gimbal_regs_t r;
		r = '{CENTER_X_RST, CENTER_Y_RST, GAIN_P_RST, GAIN_I_RST, GAIN_D_RST,
			INT_LIMIT_RST};
		case (kind)
			SET_MILD: begin
				r.center_x  = 15'($urandom_range(0, 2000));
				r.center_y  = 15'($urandom_range(0, 2000));
				r.gain_p    = 16'($urandom_range(0, 12000));
				r.gain_i    = 16'($urandom_range(0, 3000));
				r.gain_d    = 16'($urandom_range(0, 6000));
				r.int_limit = 15'($urandom_range(0, 6000));
			end
			SET_MAX: begin
				r.gain_p    = 16'hFFFF;
				r.gain_i    = 16'hFFFF;
				r.gain_d    = 16'hFFFF;
				r.int_limit = 15'h7FFF;
			end
			SET_NO_GAIN: begin
				r.gain_p = '0;
				r.gain_i = '0;
				r.gain_d = '0;
			end
			SET_NO_INTEGRAL: begin
				r.gain_i    = 16'($urandom);
				r.int_limit = '0;
			end
			SET_RANDOM: begin
				r.center_x  = 15'($urandom);
				r.center_y  = 15'($urandom);
				r.gain_p    = 16'($urandom);
				r.gain_i    = 16'($urandom);
				r.gain_d    = 16'($urandom);
				r.int_limit = 15'($urandom);
			end
			SET_EDGE_CENTER: begin
				r.center_x = $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
				r.center_y = $urandom_range(0, 1) ? 15'h7FFF : 15'h0000;
			end
			default: ;
		endcase
		return r;
	endfunction

	// a position a random distance from a point, held inside the field range
	function automatic logic [14:0] near_pos(logic [14:0] point, int spread);
		int v;
		v = int'(point) + int'($urandom_range(0, 2 * spread)) - spread;
		if (v < 0)
			v = 0;
		if (v > 32767)
			v = 32767;
		return 15'(v);
	endfunction

	function automatic logic [14:0] edge_pos(logic [14:0] center);
		case ($urandom_range(0, 2))
			0: return 15'h0000;
			1: return 15'h7FFF;
			default: return center;
		endcase
	endfunction

	// mostly tracking around the center, some drifting, some noise and extremes
	task automatic send_random_word();
		tapg_in_t w;
		int pick;
		int spread;
		pick = $urandom_range(0, 9);
		spread = ($urandom_range(0, 2) == 0) ? 3000
			: (($urandom_range(0, 1) != 0) ? 500 : 50);
		if (pick < 6) begin
			w.target_x_position = near_pos(regs.center_x, spread);
			w.target_y_position = near_pos(regs.center_y, spread);
		end else if (pick < 8) begin
			walk_x = near_pos(walk_x, 400);
			walk_y = near_pos(walk_y, 400);
			w.target_x_position = walk_x;
			w.target_y_position = walk_y;
		end else if (pick == 8) begin
			w.target_x_position = 15'($urandom);
			w.target_y_position = 15'($urandom);
		end else begin
			w.target_x_position = edge_pos(regs.center_x);
			w.target_y_position = edge_pos(regs.center_y);
		end
		send_word(w);
	endtask

	initial begin
		regs = pick_regs(SET_DEFAULT);
		phase_kinds = '{SET_MAX, SET_NO_GAIN, SET_NO_INTEGRAL, SET_EDGE_CENTER, SET_MILD,
			SET_RANDOM, SET_DEFAULT, SET_RANDOM, SET_MILD, SET_RANDOM};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero error, full-scale errors both ways, crossed axes
		send_xy(240, 320);
		send_xy(32767, 32767);
		send_xy(32767, 32767);
		send_xy(0, 0);
		send_xy(0, 0);
		send_xy(0, 32767);
		send_xy(32767, 0);
		send_xy(260, 300);
		send_xy(200, 350);
		send_xy(240, 320);
		drain();

		// zero integral limit with full integral gain
		apply_settings('{15'd240, 15'd320, 16'd3277, 16'hFFFF, 16'd655, 15'd0});
		send_xy(1000, 1000);
		send_xy(1000, 1000);
		send_xy(0, 0);
		send_xy(240, 320);
		drain();

		// centers at the top of the range, maximum gains and integral limit
		apply_settings('{15'h7FFF, 15'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF});
		send_xy(0, 0);
		send_xy(32767, 32767);
		send_xy(32767, 0);
		send_xy(0, 32767);
		drain();

		// centers at zero
		apply_settings('{15'h0000, 15'h0000, 16'hFFFF, 16'd0, 16'hFFFF, 15'd100});
		send_xy(32767, 32767);
		send_xy(0, 0);
		send_xy(16384, 16384);
		drain();

		// random phases, each under its own register setting
		for (int p = 0; p < PHASES; p++) begin
			apply_settings(pick_regs(p < 7 ? phase_kinds[p]
				: regs_kind_e'($urandom_range(0, 6))));
			walk_x = regs.center_x;
			walk_y = regs.center_y;
			for (int n = 0; n < WORDS_PER_PHASE; n++) begin
				// hold off mid-phase now and then until the pipe is empty
				if (n == WORDS_PER_PHASE / 2 && $urandom_range(0, 2) == 0)
					drain();
				send_random_word();
			end
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Checked %0d angle words under %0d register settings.",
			checked, settings_written);
		$display("%0d words had an axis at a travel stop.", at_stop);
		if (mismatches == 0 && pending == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== two_axis_pid_gimbal_step_top.f =====
rtl/core/tapg_pkg.sv
rtl/core/tapg_lane.sv
rtl/core/tapg_merge.sv
rtl/core/two_axis_pid_gimbal_step_top.sv
dv/gimbal_step_checker.sv
dv/two_axis_pid_gimbal_step_top_test.sv
